FILE: rtl/frc4_pkg.sv
package frc4_pkg;

  localparam int unsigned KeyBytes = 16;
  localparam int unsigned IvBytes  = 16;
  localparam int unsigned MaxTag   = 32;
  localparam int unsigned TagW     = $clog2(MaxTag);

  localparam logic [7:0] IvMask  = 8'h13;
  localparam logic [7:0] KeyMask = 8'h37;

  typedef enum logic [1:0] {
    ActRekey   = 2'd0,
    ActEncrypt = 2'd1,
    ActDecrypt = 2'd2,
    ActDigest  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    RegKeyLo  = 3'd0,
    RegKeyHi  = 3'd1,
    RegIvLo   = 3'd2,
    RegIvHi   = 3'd3,
    RegKeyLen = 3'd4,
    RegIvLen  = 3'd5,
    RegRounds = 3'd6,
    RegTagLen = 3'd7
  } reg_e;

  function automatic logic [7:0] pattern_byte(logic [7:0] x);
    logic [7:0] p;
    unique case (x[1:0])
      2'd0: p = 8'hff;
      2'd1: p = 8'h13;
      2'd2: p = 8'h37;
      default: p = 8'h11;
    endcase
    return p ^ {2'b00, x[7:2]};
  endfunction

endpackage

FILE: rtl/frc4_perm_ram.sv
module frc4_perm_ram import frc4_pkg::*; (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] raddr_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [256];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/feedback_rc4_cipher_engine.sv
// Feedback RC4 byte cipher engine.
// Channels: input items (action, data_in, start_i/j/q) on in_valid_i/in_ready_o,
// results (data_out, last) on out_valid_o/out_ready_i, and register writes on
// cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i, taken in any cycle.
// After reset an initialization pass loads the identity permutation into the
// permutation memory; in_ready_o stays low during it.
// One item at a time. Every step goes through the single-port-read permutation
// memory, one read or write per cycle, and each read is registered:
//   encrypt/decrypt: read S[i], read S[j], write S[j] and S[i], read S[S[i]+S[j]];
//   rekey: an identity pass, then one mix-and-swap step per round, then a result;
//   digest: 256 keystream steps, then the tag result bytes, one at a time.
// Results come from one output register; when the receiver stalls the
// sequencer holds and no result is dropped. A digest emits min(tag_len, 32) bytes,
// newest first, last set on the final one.
module feedback_rc4_cipher_engine import frc4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_in_i,
  input  logic [7:0]  start_i_i,
  input  logic [7:0]  start_j_i,
  input  logic [7:0]  start_q_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_out_o,
  output logic        last_o
);

  typedef enum logic [12:0] {
    StInit  = 13'b0000000000001,
    StIdle  = 13'b0000000000010,
    StIdent = 13'b0000000000100,
    StMix   = 13'b0000000001000,
    StRdI   = 13'b0000000010000,
    StWtI   = 13'b0000000100000,
    StRdJ   = 13'b0000001000000,
    StWtJ   = 13'b0000010000000,
    StWrJ   = 13'b0000100000000,
    StRdK   = 13'b0001000000000,
    StWtK   = 13'b0010000000000,
    StFin   = 13'b0100000000000,
    StEmit  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [63:0] key_lo_q, key_hi_q, iv_lo_q, iv_hi_q;
  logic [4:0]  key_len_q, iv_len_q;
  logic [15:0] rounds_q;
  logic [5:0]  tag_len_q;

  logic [7:0] idx_i_q, idx_j_q, fb_q;
  logic [7:0] wi_q, wj_q, wq_q;
  logic [7:0] si_q, sj_q;
  logic [1:0] act_q;
  logic [7:0] din_q, st_i_q, st_j_q, st_q_q;
  logic [15:0] cnt_q;
  logic [7:0] ki_q, vi_q;
  logic [TagW-1:0] tag_idx_q;
  logic [5:0] tag_n;
  logic [7:0] tag_mem_q [MaxTag];
  logic [7:0] out_data_q;
  logic       out_last_q, out_valid_q;

  logic       we;
  logic [7:0] waddr, wdata, raddr, rdata;

  frc4_perm_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign last_o      = out_last_q;

  logic [4:0] kl, vl;
  always_comb begin
    kl = (key_len_q == 5'd0) ? 5'd1 : (key_len_q > 5'(KeyBytes) ? 5'(KeyBytes) : key_len_q);
    vl = (iv_len_q == 5'd0) ? 5'd1 : (iv_len_q > 5'(IvBytes) ? 5'(IvBytes) : iv_len_q);
    tag_n = (tag_len_q > 6'(MaxTag)) ? 6'(MaxTag) : tag_len_q;
  end

  logic [7:0] kb, vb, mixq, pbyte, ks_out, fb_next;
  logic       rekey, digest;
  assign rekey  = (act_q == ActRekey);
  assign digest = (act_q == ActDigest);
  assign kb = ki_q[3] ? key_hi_q[8*ki_q[2:0] +: 8] : key_lo_q[8*ki_q[2:0] +: 8];
  assign vb = vi_q[3] ? iv_hi_q[8*vi_q[2:0] +: 8] : iv_lo_q[8*vi_q[2:0] +: 8];
  assign mixq  = (vb ^ IvMask) + wq_q + (kb ^ KeyMask);
  assign pbyte = digest ? pattern_byte(cnt_q[7:0]) : din_q;
  assign ks_out = pbyte ^ wq_q ^ rdata;
  assign fb_next = (act_q == ActDecrypt) ? din_q : ks_out;

  logic [15:0] limit;
  assign limit = rekey ? rounds_q : 16'd256;
  logic [7:0] cur_i;
  assign cur_i = rekey ? cnt_q[7:0] : wi_q + 8'd1;

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    waddr = cnt_q[7:0];
    wdata = cnt_q[7:0];
    raddr = cur_i;
    unique case (state_q)
      StInit, StIdent: begin
        we = 1'b1;
        if (cnt_q[7:0] == 8'hff) state_d = (state_q == StInit) ? StIdle : StMix;
      end
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          state_d = (action_i == ActRekey) ? StIdent : StRdI;
        end
      end
      StMix: state_d = (cnt_q == limit) ? StFin : StRdI;
      StRdI: state_d = StWtI;
      StWtI: state_d = StRdJ;
      StRdJ: begin
        raddr = wj_q;
        state_d = StWtJ;
      end
      StWtJ: begin
        we = 1'b1;
        waddr = wj_q;
        wdata = si_q;
        state_d = StWrJ;
      end
      StWrJ: begin
        we = 1'b1;
        waddr = wi_q;
        wdata = sj_q;
        state_d = rekey ? StMix : StRdK;
      end
      StRdK: begin
        raddr = si_q + sj_q;
        state_d = StWtK;
      end
      StWtK: begin
        if (digest) state_d = (cnt_q == 16'd255) ? StFin : StRdI;
        else if (!out_valid_q) state_d = StIdle;
      end
      StFin: begin
        if (!out_valid_q) begin
          if (rekey || tag_n == 6'd0) state_d = rekey ? StIdle : StIdle;
          else state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q && {1'b0, tag_idx_q} + 6'd1 == tag_n) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StWtK && digest && cnt_q >= 16'd256 - {10'd0, tag_n}) begin
      tag_mem_q[TagW'(8'd255 - cnt_q[7:0])] <= ks_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      key_lo_q <= '0; key_hi_q <= '0; iv_lo_q <= '0; iv_hi_q <= '0;
      key_len_q <= 5'd16; iv_len_q <= 5'd16; rounds_q <= 16'd256; tag_len_q <= 6'd16;
      idx_i_q <= '0; idx_j_q <= '0; fb_q <= '0;
      wi_q <= '0; wj_q <= '0; wq_q <= '0; si_q <= '0; sj_q <= '0;
      act_q <= ActRekey; din_q <= '0; st_i_q <= '0; st_j_q <= '0; st_q_q <= '0;
      cnt_q <= '0; ki_q <= '0; vi_q <= '0; tag_idx_q <= '0;
      out_data_q <= '0; out_last_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (reg_e'(cfg_index_i))
          RegKeyLo:  key_lo_q <= cfg_data_i;
          RegKeyHi:  key_hi_q <= cfg_data_i;
          RegIvLo:   iv_lo_q <= cfg_data_i;
          RegIvHi:   iv_hi_q <= cfg_data_i;
          RegKeyLen: key_len_q <= cfg_data_i[4:0];
          RegIvLen:  iv_len_q <= cfg_data_i[4:0];
          RegRounds: rounds_q <= cfg_data_i[15:0];
          RegTagLen: tag_len_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StInit, StIdent: cnt_q <= (cnt_q[7:0] == 8'hff) ? 16'd0 : cnt_q + 16'd1;
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            act_q <= action_i; din_q <= data_in_i;
            st_i_q <= start_i_i; st_j_q <= start_j_i; st_q_q <= start_q_i;
            cnt_q <= '0;
            ki_q <= '0; vi_q <= '0; tag_idx_q <= '0;
            if (action_i == ActRekey) begin
              wj_q <= '0; wq_q <= '0; wi_q <= '0;
            end else begin
              wi_q <= idx_i_q; wj_q <= idx_j_q; wq_q <= fb_q;
            end
          end
        end
        StMix: if (cnt_q != limit) wq_q <= mixq;
        StRdI: ;
        StWtI: begin
          si_q <= rdata;
          wj_q <= wj_q + rdata + wq_q;
          wi_q <= cur_i;
        end
        StRdJ: ;
        StWtJ: sj_q <= rdata;
        StWrJ: begin
          if (rekey) begin
            cnt_q <= cnt_q + 16'd1;
            ki_q <= ({3'd0, ki_q} + 8'd1 == {3'd0, kl} || cnt_q[7:0] == 8'hff) ? 8'd0 : ki_q + 8'd1;
            vi_q <= ({3'd0, vi_q} + 8'd1 == {3'd0, vl} || cnt_q[7:0] == 8'hff) ? 8'd0 : vi_q + 8'd1;
          end
        end
        StRdK: ;
        StWtK: begin
          if (digest) begin
            wq_q <= ks_out;
            cnt_q <= cnt_q + 16'd1;
          end else if (!out_valid_q) begin
            idx_i_q <= wi_q; idx_j_q <= wj_q; fb_q <= fb_next;
            out_data_q <= ks_out; out_last_q <= 1'b1; out_valid_q <= 1'b1;
          end
        end
        StFin: begin
          if (!out_valid_q && rekey) begin
            idx_i_q <= st_i_q; idx_j_q <= st_j_q; fb_q <= st_q_q;
            out_data_q <= '0; out_last_q <= 1'b1; out_valid_q <= 1'b1;
          end
        end
        StEmit: begin
          if (!out_valid_q) begin
            out_data_q <= tag_mem_q[tag_idx_q];
            out_last_q <= ({1'b0, tag_idx_q} + 6'd1 == tag_n);
            out_valid_q <= 1'b1;
            tag_idx_q <= tag_idx_q + TagW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
